>>> sv/data_cache_with_backing_store_top_macros.svh
// Assertion macros for the data cache top level.
`ifndef DATA_CACHE_WITH_BACKING_STORE_TOP_MACROS_SVH
`define DATA_CACHE_WITH_BACKING_STORE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define DCWB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define DCWB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dcwb_pkg.sv
// Shared types and constants of the data cache.
package dcwb_pkg;

  localparam int BLOCK_BYTES_DEF  = 16;
  localparam int SET_COUNT_DEF    = 64;
  localparam int WAY_COUNT_DEF    = 2;
  localparam int MEMORY_BYTES_DEF = 65536;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0]  FILL_BYTE     = 8'h23;
  localparam logic [31:0] PHYS_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] DEV_BASE_RST  = 32'hA000_0000;
  localparam logic [31:0] DEV_SIZE_RST  = 32'd4096;

  localparam logic [1:0] REGION_PHYS    = 2'd0;
  localparam logic [1:0] REGION_DEV     = 2'd1;
  localparam logic [1:0] REGION_INVALID = 2'd2;

  localparam logic [1:0] CFG_PHYS_BASE = 2'd0;
  localparam logic [1:0] CFG_DEV_BASE  = 2'd1;
  localparam logic [1:0] CFG_DEV_SIZE  = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_STORE   = 2'd1,
    ACT_PRELOAD = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRELOAD,
    ST_TAG_READ,
    ST_TAG_CHECK,
    ST_WRITEBACK,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_t;

endpackage

>>> sv/dcwb_classify.sv
// Address classifier: physical memory, device window or invalid.
module dcwb_classify #(
  parameter int MEMORY_BYTES = dcwb_pkg::MEMORY_BYTES_DEF
) (
  input  logic [31:0] addr,
  input  logic [31:0] physical_base,
  input  logic [31:0] device_base,
  input  logic [31:0] device_size,
  output logic [1:0]  region
);

  logic [32:0] phys_end;
  logic [32:0] dev_end;

  // bounds in 33 bits, no wrap
  assign phys_end = {1'b0, physical_base} + 33'(MEMORY_BYTES);
  assign dev_end  = {1'b0, device_base} + {1'b0, device_size};

  always_comb begin
    if (addr == device_base) begin
      region = dcwb_pkg::REGION_DEV;
    end else if (addr >= physical_base && {1'b0, addr} < phys_end) begin
      region = dcwb_pkg::REGION_PHYS;
    end else if (addr >= device_base && {1'b0, addr} < dev_end) begin
      region = dcwb_pkg::REGION_DEV;
    end else begin
      region = dcwb_pkg::REGION_INVALID;
    end
  end

endmodule

>>> sv/data_cache_with_backing_store_top.sv
// Set-associative write-back data cache over a byte-wide backing memory.
// Invalid and device words go straight to the result; a preload writes memory directly;
// a miss fills the block (one byte a cycle from memory) after, when the set is full,
// a writeback of the evicted block; a hit accesses the block; a straddle repeats lookup.
// One word at a time; the output register frees the input while a result waits.
// Reset: synchronous; then all of memory is cleared to 0x23, no input taken.
`include "data_cache_with_backing_store_top_macros.svh"

module data_cache_with_backing_store_top #(
  parameter int BLOCK_BYTES  = dcwb_pkg::BLOCK_BYTES_DEF,
  parameter int SET_COUNT    = dcwb_pkg::SET_COUNT_DEF,
  parameter int WAY_COUNT    = dcwb_pkg::WAY_COUNT_DEF,
  parameter int MEMORY_BYTES = dcwb_pkg::MEMORY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action[1:0], address[33:2], access_width[36:34], sign_extend[37],
  // write_data[69:38], zero pad[71:70]
  input  logic [dcwb_pkg::IN_TDATA_W-1:0]   s_tdata,
  // result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data[31:0], region[33:32], all_hit[34], straddled[35], zero pad[39:36]
  output logic [dcwb_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int OFF_W      = $clog2(BLOCK_BYTES);
  localparam int SET_LOG    = $clog2(SET_COUNT);
  localparam int SET_IW     = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int TAG_W      = 32 - OFF_W - SET_LOG;
  localparam int LINE_COUNT = SET_COUNT * WAY_COUNT;
  localparam int SLOT_W     = ($clog2(LINE_COUNT) > 0) ? $clog2(LINE_COUNT) : 1;
  localparam int CD_W       = SLOT_W + OFF_W;
  localparam int CD_DEPTH   = LINE_COUNT * BLOCK_BYTES;
  localparam int MEM_W      = $clog2(MEMORY_BYTES);
  localparam int WAY_W      = ($clog2(WAY_COUNT) > 0) ? $clog2(WAY_COUNT) : 1;
  localparam int CNT_W      = $clog2(BLOCK_BYTES + 1);
  localparam int ROW_W      = WAY_COUNT * TAG_W;

  dcwb_pkg::state_t state, state_next;

  // configuration registers
  logic [31:0] physical_base;
  logic [31:0] device_base;
  logic [31:0] device_size;

  // input unpack
  dcwb_pkg::action_t in_action;
  logic [31:0] in_addr;
  logic [2:0]  in_width;
  logic [2:0]  in_wc;
  logic        in_sx;
  logic [31:0] in_wd;
  logic [31:0] in_last;
  logic [1:0]  in_region;
  logic [1:0]  in_last_region;
  logic [OFF_W:0] in_pos_end;
  logic        in_crossed;

  assign in_action = dcwb_pkg::action_t'(s_tdata[1:0]);
  assign in_addr   = s_tdata[33:2];
  assign in_width  = s_tdata[36:34];
  assign in_sx     = s_tdata[37];
  assign in_wd     = s_tdata[69:38];

  // width 0 acts as 1, above 4 as 4
  always_comb begin
    if (in_width == 3'd0) begin
      in_wc = 3'd1;
    end else if (in_width > 3'd4) begin
      in_wc = 3'd4;
    end else begin
      in_wc = in_width;
    end
  end

  assign in_last    = in_addr + 32'(in_wc) - 32'd1;
  assign in_pos_end = (OFF_W+1)'(in_addr[OFF_W-1:0]) + (OFF_W+1)'(in_wc);
  assign in_crossed = in_pos_end > (OFF_W+1)'(BLOCK_BYTES);

  dcwb_classify #(.MEMORY_BYTES(MEMORY_BYTES)) u_class_first (
    .addr          (in_addr),
    .physical_base (physical_base),
    .device_base   (device_base),
    .device_size   (device_size),
    .region        (in_region)
  );

  dcwb_classify #(.MEMORY_BYTES(MEMORY_BYTES)) u_class_last (
    .addr          (in_last),
    .physical_base (physical_base),
    .device_base   (device_base),
    .device_size   (device_size),
    .region        (in_last_region)
  );

  // latched word
  dcwb_pkg::action_t act_r;
  logic [31:0] addr_r;
  logic [31:0] last_r;
  logic [2:0]  width_r;
  logic        sx_r;
  logic [31:0] wd_r;
  logic [1:0]  region_r;
  logic        crossed_r;
  logic        ok_r;        // second block is physical
  logic [2:0]  left_r;      // bytes in the first block
  logic        phase_r;     // 0 first block, 1 second block
  logic        all_hit_r;
  logic [7:0]  buf_r [4];

  // sequencing
  logic [CNT_W-1:0]  cnt_r;
  logic [MEM_W-1:0]  clr_cnt_r;
  logic [2:0]        bi_r;
  logic [WAY_W-1:0]  way_r;
  logic [SLOT_W-1:0] slot_r;
  logic              rd_pend_r;
  logic [1:0]        rd_idx_r;

  // state stores
  logic [WAY_COUNT-1:0] valid_r [SET_COUNT];
  logic [ROW_W-1:0]     tag_mem [SET_COUNT];
  logic [ROW_W-1:0]     tag_q;
  logic [7:0]           cd_mem  [CD_DEPTH];
  logic [7:0]           cd_q;
  logic [7:0]           main_mem [MEMORY_BYTES];
  logic [7:0]           mem_q;

  // lookup address of the current block
  logic [31:0]       la;
  logic [SET_IW-1:0] la_set;
  logic [TAG_W-1:0]  la_tag;
  logic [31:0]       wb_base;
  logic [31:0]       fill_base;

  assign la        = phase_r ? last_r : addr_r;
  assign la_set    = SET_IW'((la >> OFF_W) & 32'(SET_COUNT - 1));
  assign la_tag    = TAG_W'(la >> (OFF_W + SET_LOG));
  assign wb_base   = (32'(tag_q[TAG_W-1:0]) << (OFF_W + SET_LOG)) | (32'(la_set) << OFF_W);
  assign fill_base = (32'(la_tag) << (OFF_W + SET_LOG)) | (32'(la_set) << OFF_W);

  // way search
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] sel_way;
  logic [SLOT_W-1:0] sel_slot;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit && valid_r[la_set][w] && tag_q[w*TAG_W +: TAG_W] == la_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free && !valid_r[la_set][w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    // full set: way 0 is evicted
    victim_way = free ? free_way : '0;
    sel_way    = hit ? hit_way : victim_way;
    sel_slot   = SLOT_W'(32'(la_set) * WAY_COUNT + 32'(sel_way));
  end

  // access phase bounds and byte position
  logic [2:0]       acc_start;
  logic [2:0]       acc_end;
  logic [OFF_W-1:0] acc_off;
  logic             acc_last;
  logic             skip_access;

  assign acc_start   = phase_r ? left_r : 3'd0;
  assign acc_end     = phase_r ? width_r : left_r;
  assign acc_off     = phase_r ? OFF_W'(bi_r - left_r) : addr_r[OFF_W-1:0] + OFF_W'(bi_r);
  assign acc_last    = (bi_r + 3'd1) == acc_end;
  assign skip_access = !phase_r && crossed_r && !ok_r;

  logic cnt_end;
  assign cnt_end = cnt_r == CNT_W'(BLOCK_BYTES);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dcwb_pkg::ST_CLEAR: begin
        if (&clr_cnt_r) state_next = dcwb_pkg::ST_IDLE;
      end
      dcwb_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_region != dcwb_pkg::REGION_PHYS || in_action == dcwb_pkg::ACT_NONE) begin
            state_next = dcwb_pkg::ST_DONE;
          end else if (in_action == dcwb_pkg::ACT_PRELOAD) begin
            state_next = dcwb_pkg::ST_PRELOAD;
          end else begin
            state_next = dcwb_pkg::ST_TAG_READ;
          end
        end
      end
      dcwb_pkg::ST_PRELOAD: begin
        if (cnt_r[1:0] == 2'd3) state_next = dcwb_pkg::ST_DONE;
      end
      dcwb_pkg::ST_TAG_READ: begin
        state_next = dcwb_pkg::ST_TAG_CHECK;
      end
      dcwb_pkg::ST_TAG_CHECK: begin
        if (hit) begin
          state_next = skip_access ? dcwb_pkg::ST_DONE : dcwb_pkg::ST_ACCESS;
        end else if (free) begin
          state_next = dcwb_pkg::ST_FILL;
        end else begin
          state_next = dcwb_pkg::ST_WRITEBACK;
        end
      end
      dcwb_pkg::ST_WRITEBACK: begin
        if (cnt_end) state_next = dcwb_pkg::ST_FILL;
      end
      dcwb_pkg::ST_FILL: begin
        if (cnt_end) state_next = skip_access ? dcwb_pkg::ST_DONE : dcwb_pkg::ST_ACCESS;
      end
      dcwb_pkg::ST_ACCESS: begin
        if (acc_last) begin
          state_next = (!phase_r && crossed_r) ? dcwb_pkg::ST_TAG_READ : dcwb_pkg::ST_DONE;
        end
      end
      dcwb_pkg::ST_DONE: begin
        if (out_free) state_next = dcwb_pkg::ST_IDLE;
      end
      default: state_next = dcwb_pkg::ST_IDLE;
    endcase
  end

  // memory port controls
  logic             mem_we;
  logic [MEM_W-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic [MEM_W-1:0] mem_ra;
  logic             cd_we;
  logic [CD_W-1:0]  cd_wa;
  logic [7:0]       cd_wd;
  logic [CD_W-1:0]  cd_ra;
  logic             cd_re;
  logic             tag_we;
  logic [ROW_W-1:0] tag_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = MEM_W'(fill_base + 32'(cnt_r) - physical_base);
    cd_we  = 1'b0;
    cd_wa  = {slot_r, acc_off};
    cd_wd  = wd_r[8*bi_r[1:0] +: 8];
    cd_ra  = {slot_r, acc_off};
    cd_re  = 1'b0;
    tag_we = 1'b0;
    tag_wd = tag_q;
    tag_wd[way_r*TAG_W +: TAG_W] = la_tag;
    case (state)
      dcwb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = dcwb_pkg::FILL_BYTE;
      end
      dcwb_pkg::ST_PRELOAD: begin
        mem_we = 1'b1;
        mem_wa = MEM_W'({addr_r[31:2], 2'b00} + 32'(cnt_r[1:0]) - physical_base);
        mem_wd = wd_r[8*cnt_r[1:0] +: 8];
      end
      dcwb_pkg::ST_WRITEBACK: begin
        // read byte cnt, write byte cnt-1 from last cycle's read
        cd_ra  = {slot_r, OFF_W'(cnt_r)};
        mem_we = cnt_r != '0;
        mem_wa = MEM_W'(wb_base + 32'(cnt_r) - 32'd1 - physical_base);
        mem_wd = cd_q;
      end
      dcwb_pkg::ST_FILL: begin
        cd_we  = cnt_r != '0;
        cd_wa  = {slot_r, OFF_W'(CNT_W'(cnt_r - 1'b1))};
        cd_wd  = mem_q;
        tag_we = cnt_end;
      end
      dcwb_pkg::ST_ACCESS: begin
        cd_we = act_r == dcwb_pkg::ACT_STORE;
        cd_re = act_r == dcwb_pkg::ACT_LOAD;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) main_mem[mem_wa] <= mem_wd;
    mem_q <= main_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cd_we) cd_mem[cd_wa] <= cd_wd;
    cd_q <= cd_mem[cd_ra];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[la_set] <= tag_wd;
    tag_q <= tag_mem[la_set];
  end

  // result formation
  logic [7:0]  buf_eff [4];
  logic [31:0] raw;
  logic [31:0] ext;
  logic        lookup;
  logic        ok_eff;
  logic [31:0] rd_out;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      buf_eff[k] = (rd_pend_r && rd_idx_r == 2'(k)) ? cd_q : buf_r[k];
    end
    raw = {buf_eff[3], buf_eff[2], buf_eff[1], buf_eff[0]};
    case (width_r)
      3'd1: ext = {{24{sx_r & raw[7]}}, raw[7:0]};
      3'd2: ext = {{16{sx_r & raw[15]}}, raw[15:0]};
      3'd3: ext = {{8{sx_r & raw[23]}}, raw[23:0]};
      default: ext = raw;
    endcase
    lookup = region_r == dcwb_pkg::REGION_PHYS &&
             (act_r == dcwb_pkg::ACT_LOAD || act_r == dcwb_pkg::ACT_STORE);
    ok_eff = !crossed_r || ok_r;
    rd_out = (lookup && ok_eff && act_r == dcwb_pkg::ACT_LOAD) ? ext : 32'd0;
  end

  assign s_tready = state == dcwb_pkg::ST_IDLE;

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dcwb_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      m_tvalid      <= 1'b0;
      rd_pend_r     <= 1'b0;
      physical_base <= dcwb_pkg::PHYS_BASE_RST;
      device_base   <= dcwb_pkg::DEV_BASE_RST;
      device_size   <= dcwb_pkg::DEV_SIZE_RST;
      valid_r       <= '{default: '0};
    end else begin
      state     <= state_next;
      rd_pend_r <= cd_re;
      rd_idx_r  <= bi_r[1:0];
      if (rd_pend_r) buf_r[rd_idx_r] <= cd_q;

      if (cfg_we) begin
        case (cfg_index)
          dcwb_pkg::CFG_PHYS_BASE: physical_base <= cfg_data;
          dcwb_pkg::CFG_DEV_BASE:  device_base   <= cfg_data;
          dcwb_pkg::CFG_DEV_SIZE:  device_size   <= cfg_data;
          default: begin
          end
        endcase
      end

      // a result word leaving in the cycle a new one is loaded stays valid
      if (m_tvalid && m_tready && state != dcwb_pkg::ST_DONE) m_tvalid <= 1'b0;

      case (state)
        dcwb_pkg::ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        dcwb_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            act_r     <= in_action;
            addr_r    <= in_addr;
            last_r    <= in_last;
            width_r   <= in_wc;
            sx_r      <= in_sx;
            wd_r      <= in_wd;
            region_r  <= in_region;
            crossed_r <= in_crossed;
            ok_r      <= in_last_region == dcwb_pkg::REGION_PHYS;
            left_r    <= in_crossed ?
                         3'((OFF_W+1)'(BLOCK_BYTES) - (OFF_W+1)'(in_addr[OFF_W-1:0])) : in_wc;
            phase_r   <= 1'b0;
            all_hit_r <= 1'b1;
            cnt_r     <= '0;
            buf_r     <= '{default: '0};
          end
        end
        dcwb_pkg::ST_PRELOAD: begin
          cnt_r <= cnt_r + 1'b1;
        end
        dcwb_pkg::ST_TAG_CHECK: begin
          way_r  <= sel_way;
          slot_r <= sel_slot;
          bi_r   <= acc_start;
          cnt_r  <= '0;
          if (!hit) all_hit_r <= 1'b0;
        end
        dcwb_pkg::ST_WRITEBACK: begin
          cnt_r <= cnt_end ? '0 : cnt_r + 1'b1;
        end
        dcwb_pkg::ST_FILL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_end) valid_r[la_set][way_r] <= 1'b1;
        end
        dcwb_pkg::ST_ACCESS: begin
          bi_r <= bi_r + 3'd1;
          if (acc_last && !phase_r && crossed_r) phase_r <= 1'b1;
        end
        dcwb_pkg::ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, lookup & crossed_r, lookup & all_hit_r, region_r, rd_out};
          end
        end
        default: begin
        end
      endcase
    end
  end

  `DCWB_ASSERT_IMP(a_out_from_done, $rose(m_tvalid), $past(state) == dcwb_pkg::ST_DONE, "result word raised outside the result state")
  `DCWB_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, state != dcwb_pkg::ST_IDLE, "block idle right after taking a word")
  `DCWB_ASSERT_IMP(a_flags_physical, m_tvalid && (m_tdata[35] || m_tdata[34]), m_tdata[33:32] == dcwb_pkg::REGION_PHYS, "hit or straddle flag on a non-physical word")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the set-associative write-back data cache.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK      = dcwb_pkg::BLOCK_BYTES_DEF;
  localparam int SETS     = dcwb_pkg::SET_COUNT_DEF;
  localparam int WAYS     = dcwb_pkg::WAY_COUNT_DEF;
  localparam int MEM_SZ   = dcwb_pkg::MEMORY_BYTES_DEF;
  localparam int LINES    = SETS * WAYS;
  localparam int SPAN     = BLK * SETS;
  localparam int IDLE_LIM = 400000;  // well above the post-reset memory clear
  localparam int DRAIN    = 120;     // worst case: two writebacks plus two fills

  typedef struct packed {
    dcwb_pkg::action_t act;
    logic [31:0] addr;
    logic [2:0]  width;
    logic        sx;
    logic [31:0] wd;
  } access_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [1:0]  region;
    logic        hit;
    logic        strad;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [dcwb_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [dcwb_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = dcwb_pkg::CFG_PHYS_BASE;
  logic [31:0] cfg_data = '0;

  // shadow of the cache and its memory
  logic [31:0] phys_base, dev_base, dev_size;
  bit          blk_valid[LINES];
  logic [21:0] blk_tag[LINES];
  logic [7:0]  blk_bytes[LINES*BLK];
  logic [7:0]  mem_img[MEM_SZ];

  outcome_t expected_q[$];
  int   errors;
  bit   quiet;       // no idling on either side
  int   hold_left;   // receiver hold-off, cycles
  int   stall_left;
  int   idle_cnt;

  always #1 clk = ~clk;

  data_cache_with_backing_store_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [1:0] region_of(input logic [31:0] a);
    if (a == dev_base) return dcwb_pkg::REGION_DEV;
    if (a >= phys_base && 64'(a) < 64'(phys_base) + 64'(MEM_SZ)) return dcwb_pkg::REGION_PHYS;
    if (a >= dev_base && 64'(a) < 64'(dev_base) + 64'(dev_size)) return dcwb_pkg::REGION_DEV;
    return dcwb_pkg::REGION_INVALID;
  endfunction

  function automatic int mem_at(input logic [31:0] a);
    logic [31:0] off;
    off = a - phys_base;
    return int'(off % MEM_SZ);
  endfunction

  // Look up the block of a; on a miss fill the first free way, else evict way 0.
  function automatic int lookup_block(input logic [31:0] a, output bit hit);
    logic [31:0] al, tag, set, base;
    int first, slot;
    bit free_found;
    al = a & ~32'd3;
    tag = al / SPAN;
    set = (al % SPAN) / BLK;
    first = int'(set) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (blk_valid[first+w] && blk_tag[first+w] == tag[21:0]) begin
        hit = 1'b1;
        return first + w;
      end
    end
    hit = 1'b0;
    slot = first;
    free_found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!blk_valid[first+w]) begin
        slot = first + w;
        free_found = 1'b1;
        break;
      end
    end
    if (!free_found) begin
      base = 32'(blk_tag[slot]) * SPAN + set * BLK;
      for (int i = 0; i < BLK; i++) mem_img[mem_at(base + i)] = blk_bytes[slot*BLK+i];
    end
    base = tag * SPAN + set * BLK;
    for (int i = 0; i < BLK; i++) blk_bytes[slot*BLK+i] = mem_img[mem_at(base + i)];
    blk_valid[slot] = 1'b1;
    blk_tag[slot] = tag[21:0];
    return slot;
  endfunction

  function automatic outcome_t cache_access(input access_t t);
    outcome_t r;
    int w, s1, s2, pos, left;
    bit h1, h2, ok;
    logic [31:0] last, mask;
    logic [7:0] buf4[4];
    r = '0;
    r.region = region_of(t.addr);
    w = (t.width == 0) ? 1 : (t.width > 4) ? 4 : int'(t.width);
    buf4 = '{default: 8'h00};
    if (r.region == dcwb_pkg::REGION_PHYS && t.act == dcwb_pkg::ACT_PRELOAD) begin
      for (int i = 0; i < 4; i++)
        mem_img[mem_at((t.addr & ~32'd3) + i)] = t.wd[8*i +: 8];
    end else if (r.region == dcwb_pkg::REGION_PHYS &&
                 (t.act == dcwb_pkg::ACT_LOAD || t.act == dcwb_pkg::ACT_STORE)) begin
      s1 = lookup_block(t.addr, h1);
      pos = int'(t.addr % BLK);
      last = t.addr + w - 1;
      left = w;
      ok = 1'b1;
      r.hit = h1;
      if (pos + w > BLK) begin
        r.strad = 1'b1;
        left = BLK - pos;
        if (region_of(last) != dcwb_pkg::REGION_PHYS) ok = 1'b0;
      end
      if (ok) begin
        for (int i = 0; i < left; i++) begin
          if (t.act == dcwb_pkg::ACT_LOAD) buf4[i] = blk_bytes[s1*BLK+pos+i];
          else blk_bytes[s1*BLK+pos+i] = t.wd[8*i +: 8];
        end
        if (r.strad) begin
          // store bytes of the first block land before this fill may evict it
          s2 = lookup_block(last, h2);
          if (!h2) r.hit = 1'b0;
          for (int i = left; i < w; i++) begin
            if (t.act == dcwb_pkg::ACT_LOAD) buf4[i] = blk_bytes[s2*BLK+i-left];
            else blk_bytes[s2*BLK+i-left] = t.wd[8*i +: 8];
          end
        end
        if (t.act == dcwb_pkg::ACT_LOAD) begin
          mask = (w == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8*w)) - 1);
          r.rd = {buf4[3], buf4[2], buf4[1], buf4[0]} & mask;
          if (t.sx && w < 4 && r.rd[8*w-1]) r.rd |= ~mask;
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = '{rd: m_tdata[31:0], region: m_tdata[33:32], hit: m_tdata[34],
              strad: m_tdata[35]};
      if (expected_q.size() == 0) begin
        report("unexpected word", 32'(m_tdata), 32'd0);
      end else begin
        exp = expected_q.pop_front();
        if (got.rd !== exp.rd) report("read_data", got.rd, exp.rd);
        if (got.region !== exp.region) report("region", got.region, exp.region);
        if (got.hit !== exp.hit) report("all_hit", got.hit, exp.hit);
        if (got.strad !== exp.strad) report("straddled", got.strad, exp.strad);
      end
    end
  end

  // receiver: random stall bursts, optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIM) begin
      $display("data_cache_with_backing_store_top verification failed");
      $finish;
    end
  end

  task automatic send_word(input access_t t);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, t.wd, t.sx, t.width, t.addr, t.act};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(cache_access(t));
  endtask

  task automatic send(input dcwb_pkg::action_t a, input logic [31:0] addr,
                      input logic [2:0] w, input logic sx, input logic [31:0] wd);
    send_word('{act: a, addr: addr, width: w, sx: sx, wd: wd});
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dcwb_pkg::CFG_PHYS_BASE: phys_base = val;
      dcwb_pkg::CFG_DEV_BASE:  dev_base = val;
      default:                 dev_size = val;
    endcase
  endtask

  function automatic access_t random_access();
    access_t t;
    int pick;
    pick = $urandom_range(0, 99);
    t.act = dcwb_pkg::action_t'((pick < 40) ? dcwb_pkg::ACT_LOAD :
                                (pick < 75) ? dcwb_pkg::ACT_STORE :
                                (pick < 92) ? dcwb_pkg::ACT_PRELOAD : dcwb_pkg::ACT_NONE);
    pick = $urandom_range(0, 99);
    if (pick < 70) t.addr = phys_base + $urandom_range(0, 4095);       // set conflicts
    else if (pick < 78) t.addr = phys_base + $urandom_range(0, MEM_SZ - 1);
    else if (pick < 84) t.addr = phys_base + MEM_SZ - $urandom_range(1, 8);
    else if (pick < 92) t.addr = dev_base + $urandom_range(0, 8) - 2;
    else t.addr = $urandom;
    pick = $urandom_range(0, 9);
    t.width = (pick < 3) ? 3'd4 : (pick < 5) ? 3'd2 : (pick < 7) ? 3'd1 : 3'($urandom_range(0, 7));
    t.sx = 1'($urandom);
    t.wd = $urandom;
    return t;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_word(random_access());
  endtask

  // edges of every field, all actions, straddles, eviction, regions
  task automatic test_directed();
    logic [31:0] b;
    b = phys_base;
    send(dcwb_pkg::ACT_LOAD, b, 3'd4, 1'b0, 32'h0);               // fresh fill, 0x23 pattern
    send(dcwb_pkg::ACT_STORE, b + 4, 3'd2, 1'b0, 32'hFFFF_FF80);
    send(dcwb_pkg::ACT_LOAD, b + 4, 3'd1, 1'b1, 32'h0);           // sign-extended byte
    send(dcwb_pkg::ACT_LOAD, b + 4, 3'd2, 1'b1, 32'h0);
    send(dcwb_pkg::ACT_LOAD, b + 4, 3'd2, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_LOAD, b + 4, 3'd0, 1'b1, 32'h0);           // width 0 acts as 1
    send(dcwb_pkg::ACT_LOAD, b + 4, 3'd7, 1'b1, 32'h0);           // above 4 acts as 4
    send(dcwb_pkg::ACT_STORE, b + 14, 3'd4, 1'b0, 32'hDEAD_BEEF); // straddle
    send(dcwb_pkg::ACT_LOAD, b + 13, 3'd4, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_STORE, b + MEM_SZ - 2, 3'd4, 1'b0, 32'h1234_5678); // second block out
    send(dcwb_pkg::ACT_LOAD, b + MEM_SZ - 2, 3'd4, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_PRELOAD, b + 1027, 3'd1, 1'b0, 32'hA5A5_5A5A);
    send(dcwb_pkg::ACT_LOAD, b + 1024, 3'd4, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_STORE, b + 2048, 3'd4, 1'b0, 32'h0BAD_F00D); // third tag: evict way 0
    send(dcwb_pkg::ACT_LOAD, b, 3'd4, 1'b0, 32'h0);                // refetch after writeback
    send(dcwb_pkg::ACT_NONE, b, 3'd4, 1'b1, 32'hFFFF_FFFF);
    send(dcwb_pkg::ACT_LOAD, dev_base, 3'd4, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_STORE, dev_base + 100, 3'd1, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_LOAD, 32'hFFFF_FFFF, 3'd4, 1'b1, 32'h0);
    send(dcwb_pkg::ACT_LOAD, 32'h0000_0000, 3'd1, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_PRELOAD, 32'h1234_5678, 3'd4, 1'b0, 32'h0);
  endtask

  // extreme register settings, each followed by random traffic
  task automatic test_config_extremes();
    write_reg(dcwb_pkg::CFG_PHYS_BASE, 32'h0000_0000);
    write_reg(dcwb_pkg::CFG_DEV_BASE, 32'h0000_0100);  // device base inside physical range
    write_reg(dcwb_pkg::CFG_DEV_SIZE, 32'd1);
    send(dcwb_pkg::ACT_LOAD, 32'h0000_0100, 3'd4, 1'b0, 32'h0);
    send(dcwb_pkg::ACT_LOAD, 32'h0000_0FFE, 3'd4, 1'b1, 32'h0);
    run_random(250);
    write_reg(dcwb_pkg::CFG_PHYS_BASE, 32'hFFFF_0000);
    write_reg(dcwb_pkg::CFG_DEV_BASE, 32'h0000_0000);
    write_reg(dcwb_pkg::CFG_DEV_SIZE, 32'hFFFF_FFFF);
    send(dcwb_pkg::ACT_STORE, 32'hFFFF_FFFE, 3'd4, 1'b0, 32'hCAFE_BABE); // wraps past top
    send(dcwb_pkg::ACT_LOAD, 32'hFFFF_FFFC, 3'd4, 1'b0, 32'h0);
    run_random(250);
    write_reg(dcwb_pkg::CFG_PHYS_BASE, 32'h4000_0000);
    write_reg(dcwb_pkg::CFG_DEV_BASE, 32'hFFFF_FFFF);
    write_reg(dcwb_pkg::CFG_DEV_SIZE, 32'h0001_0000);
    run_random(250);
  endtask

  // block fills up while the receiver holds off
  task automatic test_backpressure();
    hold_left = 400;
    run_random(60);
  endtask

  task automatic test_random_mix();
    write_reg(dcwb_pkg::CFG_PHYS_BASE, dcwb_pkg::PHYS_BASE_RST);
    write_reg(dcwb_pkg::CFG_DEV_BASE, dcwb_pkg::DEV_BASE_RST);
    write_reg(dcwb_pkg::CFG_DEV_SIZE, dcwb_pkg::DEV_SIZE_RST);
    run_random(600);
    write_reg(dcwb_pkg::CFG_PHYS_BASE, 32'h8000_8000);  // same cache, shifted image
    run_random(200);
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    run_random(200);
  endtask

  initial begin
    phys_base = dcwb_pkg::PHYS_BASE_RST;
    dev_base = dcwb_pkg::DEV_BASE_RST;
    dev_size = dcwb_pkg::DEV_SIZE_RST;
    foreach (blk_valid[i]) blk_valid[i] = 1'b0;
    foreach (blk_tag[i]) blk_tag[i] = '0;
    foreach (blk_bytes[i]) blk_bytes[i] = '0;
    foreach (mem_img[i]) mem_img[i] = dcwb_pkg::FILL_BYTE;
    errors = 0;
    quiet = 1'b0;
    hold_left = 0;
    stall_left = 0;
    idle_cnt = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_mix();
    test_no_idle();

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("data_cache_with_backing_store_top verification clean");
    else $display("data_cache_with_backing_store_top verification failed");
    $finish;
  end

endmodule
